/* rtl/crbs_pkg.sv */
// Package for the card read block splitter.
// Holds field widths, the queued request type and the command type.
// No dependencies.
package crbs_pkg;

	// Field widths of the request and command channels.
	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 15;
	localparam int FLAGS_W = 32;
	localparam int SKIP_W  = 9;
	localparam int COPY_W  = 10;

	// Upper bound on commands emitted for one request.
	localparam int MAX_RESULTS = 34;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// Depth of the queue between the front and back parts.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// A request as held in the queue, with its count already saturated.
	typedef struct packed {
		logic [ADDR_W-1:0]  start_offset;
		logic [LEN_W-1:0]   byte_count;
		logic [ADDR_W-1:0]  dest_addr;
		logic [FLAGS_W-1:0] control_flags;
	} req_t;

	// One block read command.
	typedef struct packed {
		logic [ADDR_W-1:0]  chunk_offset;
		logic               use_buffer;
		logic [SKIP_W-1:0]  skip_bytes;
		logic [COPY_W-1:0]  copy_bytes;
		logic [ADDR_W-1:0]  chunk_dest;
		logic [FLAGS_W-1:0] chunk_flags;
		logic               last_chunk;
	} cmd_t;

endpackage

/* rtl/crbs_if.sv */
// Channel interfaces of the card read block splitter: request and command.
// Depends on crbs_pkg for the field widths.

interface crbs_req_if;
	import crbs_pkg::*;

	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  start_offset;
	logic [LEN_W-1:0]   byte_count;
	logic [ADDR_W-1:0]  dest_addr;
	logic [FLAGS_W-1:0] control_flags;

	modport source (output valid, start_offset, byte_count, dest_addr, control_flags,
		input ready);
	modport sink (input valid, start_offset, byte_count, dest_addr, control_flags,
		output ready);
endinterface

interface crbs_cmd_if;
	import crbs_pkg::*;

	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  chunk_offset;
	logic               use_buffer;
	logic [SKIP_W-1:0]  skip_bytes;
	logic [COPY_W-1:0]  copy_bytes;
	logic [ADDR_W-1:0]  chunk_dest;
	logic [FLAGS_W-1:0] chunk_flags;
	logic               last_chunk;

	modport source (output valid, chunk_offset, use_buffer, skip_bytes, copy_bytes,
		chunk_dest, chunk_flags, last_chunk, input ready);
	modport sink (input valid, chunk_offset, use_buffer, skip_bytes, copy_bytes,
		chunk_dest, chunk_flags, last_chunk, output ready);
endinterface

/* rtl/crbs_front.sv */
// Front part of the card read block splitter: takes requests, saturates
// the byte count and drops empty requests. Depends on crbs_pkg, crbs_if.
module crbs_front #(
	parameter int MAX_REQUEST_BYTES = 16384
) (
	crbs_req_if.sink        req,
	output logic            push_valid,
	input  logic            push_ready,
	output crbs_pkg::req_t  push_data
);
	import crbs_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_REQUEST_BYTES);

	logic [LEN_W-1:0] len_sat;

	// Clamp the count to the largest request the block serves.
	assign len_sat = (req.byte_count > MAX_LEN) ? MAX_LEN : req.byte_count;

	// A request with nothing to read is taken and dropped here.
	assign req.ready  = push_ready;
	assign push_valid = req.valid && (req.byte_count != '0);

	assign push_data.start_offset  = req.start_offset;
	assign push_data.byte_count    = len_sat;
	assign push_data.dest_addr     = req.dest_addr;
	assign push_data.control_flags = req.control_flags;

endmodule

/* rtl/crbs_queue.sv */
// Short request queue between the front and back parts of the splitter.
// Depends on crbs_pkg for the request type and queue depth.
module crbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  crbs_pkg::req_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output crbs_pkg::req_t pop_data
);
	import crbs_pkg::*;

	req_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage; no reset needed for payload.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/crbs_back.sv */
// Back part of the card read block splitter: walks one request and
// emits one block read command per cycle into an output register unless the
// receiver holds ready low. Depends on crbs_pkg and crbs_if.
module crbs_back #(
	parameter int BLOCK_BYTES = 512,
	parameter int PAGE_BYTES  = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  crbs_pkg::req_t job_data,
	crbs_cmd_if.source     cmd
);
	import crbs_pkg::*;

	// Block and page sizes must be powers of two; the block does not check this.
	localparam int BLK_W = $clog2(BLOCK_BYTES);
	localparam int PG_W  = $clog2(PAGE_BYTES);
	localparam int MW0   = (LEN_W > PG_W) ? LEN_W : PG_W;
	localparam int MW1   = (MW0 > BLK_W) ? MW0 : BLK_W;
	localparam int AW    = MW1 + 2;
	localparam logic [ADDR_W-1:0] BLK_MASK = ADDR_W'(BLOCK_BYTES - 1);
	localparam logic [AW-1:0] BLK_X  = AW'(BLOCK_BYTES);
	localparam logic [AW-1:0] PAGE_X = AW'(PAGE_BYTES);

	// Working state of the request being split.
	logic               busy_q;
	logic [ADDR_W-1:0]  off_q;
	logic [LEN_W-1:0]   len_q;
	logic [ADDR_W-1:0]  dst_q;
	logic [FLAGS_W-1:0] flg_q;
	logic [CNT_W-1:0]   n_q;

	// Output register.
	logic               out_valid_q;
	cmd_t               out_q;

	logic [ADDR_W-1:0]  base;
	logic [AW-1:0]      skip_x;
	logic [AW-1:0]      len_x;
	logic [AW-1:0]      room;
	logic [AW-1:0]      span_sum;
	logic [AW-1:0]      span_blk;
	logic [AW-1:0]      span_pg;
	logic [AW-1:0]      copy_dir;
	logic [AW-1:0]      copy_buf;
	logic [AW-1:0]      copy;
	logic               direct;
	logic [LEN_W-1:0]   len_next;
	logic               last;
	logic               emit;
	logic               load;

	// Split the current offset into its block base and the bytes to skip.
	assign base   = off_q & ~BLK_MASK;
	assign skip_x = AW'(off_q[BLK_W-1:0]);
	assign len_x  = AW'(len_q);
	assign room   = PAGE_X - AW'(base[PG_W-1:0]);

	// A direct read needs aligned offset and destination and a whole block left.
	assign direct = (off_q[BLK_W-1:0] == '0) && (dst_q[BLK_W-1:0] == '0)
		&& (len_x >= BLK_X);
	assign copy_dir = (BLK_X > room) ? room : BLK_X;

	// Buffered read: cap at the block end, then at the page end if that leaves bytes.
	assign span_sum = len_x + skip_x;
	assign span_blk = (span_sum > BLK_X) ? BLK_X : span_sum;
	assign span_pg  = ((span_blk > room) && (room > skip_x)) ? room : span_blk;
	assign copy_buf = span_pg - skip_x;

	assign copy     = direct ? copy_dir : copy_buf;
	assign len_next = len_q - copy[LEN_W-1:0];
	assign last     = (len_next == '0) || (n_q == CNT_W'(MAX_RESULTS - 1));

	assign emit      = busy_q && (!out_valid_q || cmd.ready);
	assign job_ready = !busy_q;
	assign load      = job_valid && !busy_q;

	// Control state: busy flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers advance by the bytes each command delivers.
	always_ff @(posedge clk) begin
		if (load) begin
			off_q <= job_data.start_offset;
			len_q <= job_data.byte_count;
			dst_q <= job_data.dest_addr;
			flg_q <= job_data.control_flags;
			n_q   <= '0;
		end else if (emit) begin
			off_q <= off_q + ADDR_W'(copy);
			len_q <= len_next;
			dst_q <= dst_q + ADDR_W'(copy);
			n_q   <= n_q + 1'b1;
		end
	end

	// Command payload register.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.chunk_offset <= base;
			out_q.use_buffer   <= !direct;
			out_q.skip_bytes   <= skip_x[SKIP_W-1:0];
			out_q.copy_bytes   <= copy[COPY_W-1:0];
			out_q.chunk_dest   <= dst_q;
			out_q.chunk_flags  <= flg_q;
			out_q.last_chunk   <= last;
		end
	end

	assign cmd.valid        = out_valid_q;
	assign cmd.chunk_offset = out_q.chunk_offset;
	assign cmd.use_buffer   = out_q.use_buffer;
	assign cmd.skip_bytes   = out_q.skip_bytes;
	assign cmd.copy_bytes   = out_q.copy_bytes;
	assign cmd.chunk_dest   = out_q.chunk_dest;
	assign cmd.chunk_flags  = out_q.chunk_flags;
	assign cmd.last_chunk   = out_q.last_chunk;

endmodule

/* rtl/card_read_block_splitter.sv */
// Card read block splitter: turns one card read request into block read commands.
// Request channel req (sink): start_offset, byte_count, dest_addr, control_flags.
// Command channel cmd (source): chunk_offset, use_buffer, skip_bytes, copy_bytes,
// chunk_dest, chunk_flags, last_chunk. Each channel moves one item per transfer
// when valid and ready are both high.
// A request enters a two-entry queue; the splitting unit takes it when idle and
// produces one command per cycle while ready is high. The first command passes the
// queue, the working registers and the output register before it is valid.
// A request holds the splitting unit until its last command; at the largest size an
// unaligned start gives 33 commands, and a run is always cut after 34 commands. A
// zero byte count is taken and yields no command. Counts above MAX_REQUEST_BYTES
// are clamped. The last command of each request carries last_chunk.
// When the receiver holds ready low, the output register keeps its command and the
// splitting unit waits; the queue still takes up to two further requests.
// Reset empties the queue and the output register and drops any request in work.
// Depends on crbs_pkg, crbs_if, crbs_front, crbs_queue and crbs_back.
module card_read_block_splitter #(
	parameter int BLOCK_BYTES       = 512,
	parameter int PAGE_BYTES        = 4096,
	parameter int MAX_REQUEST_BYTES = 16384
) (
	input  logic       clk,
	input  logic       arst_n,
	crbs_req_if.sink   req,
	crbs_cmd_if.source cmd
);
	import crbs_pkg::*;

	logic push_valid;
	logic push_ready;
	req_t push_data;
	logic job_valid;
	logic job_ready;
	req_t job_data;

	// Front: clamp and filter.
	crbs_front #(
		.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
	) u_front (
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// Queue between front and back.
	crbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (job_valid),
		.pop_ready (job_ready),
		.pop_data  (job_data)
	);

	// Back: command generation.
	crbs_back #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_data (job_data),
		.cmd      (cmd)
	);

	// Every command reads from a block-aligned card offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> ((cmd.chunk_offset & ADDR_W'(BLOCK_BYTES - 1)) == '0))
		else $error("command offset not block aligned");

	// A direct command skips nothing and writes to an aligned destination.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && !cmd.use_buffer) |->
		((cmd.skip_bytes == '0) && ((cmd.chunk_dest & ADDR_W'(BLOCK_BYTES - 1)) == '0)))
		else $error("direct command not aligned");

	// Commands of one request follow each other without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && !cmd.last_chunk) |=> cmd.valid)
		else $error("gap inside a command run");

	// The control word stays the same across one request's commands.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && !cmd.last_chunk) |=> $stable(cmd.chunk_flags))
		else $error("control word changed inside a command run");

endmodule
